// ----- rtl/rsc_pkg.sv -----
// shared types, constants and mod-26 helpers for the three-rotor cipher
// no dependencies; compiled before every other file of the block
package rsc_pkg;

    localparam int ROTOR_COUNT = 3;
    localparam int LETTERS     = 26;
    localparam int STAGES      = 2 * ROTOR_COUNT;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [7:0] CHAR_LOW    = 8'd97;
    localparam logic [7:0] CHAR_HIGH   = 8'd122;
    localparam logic [6:0] ASCII_A     = 7'd97;
    localparam logic [4:0] LAST_LETTER = 5'd25;

    typedef logic [4:0] letter_t;
    typedef letter_t [ROTOR_COUNT-1:0] offsets_t;

    typedef enum logic {
        KIND_LOAD,
        KIND_LETTER
    } kind_t;

    // one queued request: a wiring load or a letter to encipher
    // for a letter, pos carries the letter index
    typedef struct packed {
        kind_t    kind;
        logic [1:0] rotor;
        letter_t  pos;
        letter_t  val;
        offsets_t offs;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic letter_t add_mod26(letter_t a, letter_t b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 6'(LETTERS)) ? 5'(s - 6'(LETTERS)) : s[4:0];
    endfunction

    function automatic letter_t sub_mod26(letter_t a, letter_t b);
        logic [5:0] s;
        s = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
        return (s >= 6'(LETTERS)) ? 5'(s - 6'(LETTERS)) : s[4:0];
    endfunction

endpackage

// ----- rtl/rsc_req_if.sv -----
// request channel of the three-rotor cipher: valid/ready plus request fields
// no dependencies
interface rsc_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [1:0] rotor_select;
    logic [4:0] wiring_position;
    logic [4:0] wiring_value;
    logic [7:0] char_in;

    modport source (
        output valid, req_type, rotor_select, wiring_position, wiring_value, char_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, rotor_select, wiring_position, wiring_value, char_in,
        output ready
    );
endinterface

// ----- rtl/rsc_res_if.sv -----
// result channel of the three-rotor cipher: valid/ready plus the cipher letter
// no dependencies
interface rsc_res_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_char;

    modport source (
        output valid, cipher_char,
        input  ready
    );
    modport sink (
        input  valid, cipher_char,
        output ready
    );
endinterface

// ----- rtl/rsc_front.sv -----
// front end: accepts requests, classifies them and keeps the rotor odometer
// depends on rsc_pkg and rsc_req_if
module rsc_front
    import rsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rsc_req_if.sink   req,
    input  q_status_t q_status,
    output logic      push,
    output item_t     push_item
);

    offsets_t offs_reg;
    offsets_t offs_next;
    logic     accept;
    logic     is_letter;
    logic     load_ok;
    logic     step;

    assign req.ready = !q_status.full;
    assign accept    = req.valid && req.ready;

    assign is_letter = (req.char_in >= CHAR_LOW) && (req.char_in <= CHAR_HIGH);
    assign load_ok   = (32'(req.rotor_select) < ROTOR_COUNT)
                    && (req.wiring_position <= LAST_LETTER)
                    && (req.wiring_value <= LAST_LETTER);

    // non-letters and bad loads are dropped here
    assign push = accept && (req.req_type ? is_letter : load_ok);

    always_comb
    begin
        push_item.kind  = req.req_type ? KIND_LETTER : KIND_LOAD;
        push_item.rotor = req.rotor_select;
        push_item.pos   = req.req_type ? 5'(req.char_in - CHAR_LOW) : req.wiring_position;
        push_item.val   = req.wiring_value;
        push_item.offs  = offs_reg;
    end

    // odometer: each rotor steps when all before it wrap
    always_comb
    begin
        offs_next = offs_reg;
        step      = accept && req.req_type;
        for (int r = 0; r < ROTOR_COUNT; r++)
        begin
            if (step)
            begin
                offs_next[r] = (offs_reg[r] == LAST_LETTER) ? '0 : offs_reg[r] + 5'd1;
                step         = (offs_reg[r] == LAST_LETTER);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offs_reg <= '0;
        end
        else
        begin
            offs_reg <= offs_next;
        end
    end

    a_load_holds_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !req.req_type) |=> (offs_reg == $past(offs_reg)))
        else $error("load request moved the rotor offsets");

    a_fast_rotor_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type) |=> (offs_reg[0] == add_mod26($past(offs_reg[0]), 5'd1)))
        else $error("fast rotor did not step on a character request");

endmodule

// ----- rtl/rsc_queue.sv -----
// short queue between front end and rotor pipeline
// depends on rsc_pkg
module rsc_queue
    import rsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     head,
    output q_status_t status
);

    item_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign status.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

// ----- rtl/rsc_back.sv -----
// rotor pipeline: one table lookup per stage, forward rotors then inverse
// rotors, loads write each table at the stage that reads it; output register
// depends on rsc_pkg and rsc_res_if
module rsc_back
    import rsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  item_t     head,
    output logic      pop,
    rsc_res_if.source res
);

    logic    en;
    logic    vld_reg  [STAGES+1];
    item_t   meta_reg [STAGES+1];
    letter_t rd_reg   [STAGES];
    logic    out_valid_reg;
    logic [6:0] char_reg;
    logic    final_letter;

    assign en  = !out_valid_reg || res.ready;
    assign pop = en && !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= pop;
            for (int s = 0; s < STAGES; s++)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= head;
            for (int s = 0; s < STAGES; s++)
            begin
                meta_reg[s+1] <= meta_reg[s];
            end
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        letter_t rot_mem [LETTERS];
        letter_t stage_val;
        letter_t addr;
        letter_t waddr;
        letter_t wdata;
        logic    we;
        logic    is_load;

        assign is_load = vld_reg[s] && (meta_reg[s].kind == KIND_LOAD);

        if (s == 0)
        begin : g_first
            assign stage_val = meta_reg[0].pos;
        end
        else
        begin : g_next
            assign stage_val = rd_reg[s-1];
        end

        if (s < ROTOR_COUNT)
        begin : g_fwd
            // forward wiring of rotor s
            assign addr  = add_mod26(stage_val, meta_reg[s].offs[s]);
            assign we    = is_load && (32'(meta_reg[s].rotor) == s);
            assign waddr = meta_reg[s].pos;
            assign wdata = meta_reg[s].val;
        end
        else
        begin : g_inv
            // inverse wiring of rotor STAGES-1-s
            localparam int RB = STAGES - 1 - s;
            if (s == ROTOR_COUNT)
            begin : g_reflect
                assign addr = LAST_LETTER - stage_val;
            end
            else
            begin : g_unshift
                assign addr = sub_mod26(stage_val, meta_reg[s].offs[RB+1]);
            end
            assign we    = is_load && (32'(meta_reg[s].rotor) == RB);
            assign waddr = meta_reg[s].val;
            assign wdata = meta_reg[s].pos;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (we)
                begin
                    rot_mem[waddr] <= wdata;
                end
                rd_reg[s] <= rot_mem[addr];
            end
        end
    end

    assign final_letter = vld_reg[STAGES] && (meta_reg[STAGES].kind == KIND_LETTER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= final_letter;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && final_letter)
        begin
            char_reg <= ASCII_A
                      + {2'b00, sub_mod26(rd_reg[STAGES-1], meta_reg[STAGES].offs[0])};
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.cipher_char = char_reg;

    a_letter_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (en && final_letter) |=> out_valid_reg)
        else $error("finished letter did not reach the output register");

    a_stall_freezes_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (vld_reg[STAGES] == $past(vld_reg[STAGES])))
        else $error("pipeline moved during output stall");

endmodule

// ----- rtl/three_rotor_substitution_cipher_top.sv -----
// three-rotor substitution cipher, top level
// depends on rsc_pkg, rsc_req_if, rsc_res_if, rsc_front, rsc_queue, rsc_back
//
// usage
// - req channel (valid/ready): req_type 0 loads one wiring entry of the
//   rotor given by rotor_select (position -> value, plus the inverse entry);
//   req_type 1 enciphers char_in; only 'a'..'z' give a result
// - res channel (valid/ready): one cipher_char (ascii 'a'..'z') per letter
// - every character request, letter or not, steps the rotor odometer;
//   loads and out-of-range loads do not
// - throughput: one request per cycle while the queue is not full, with or without results
// - path of a letter: the queue, one rotor table lookup per stage (forward
//   and inverse), then the output register, before it shows on res
// - the lookup pipeline has one table per stage, each written by loads at
//   the same stage that reads it, so loads and letters keep request order
// - a stalled res freezes the whole lookup pipeline; the 4-entry queue keeps
//   taking requests until full, then req.ready drops
// - reset clears the offsets, the queue and all valid flags; rotor tables
//   hold garbage until loaded, so load all wiring before enciphering
module three_rotor_substitution_cipher_top
    import rsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rsc_req_if.sink   req,
    rsc_res_if.source res
);

    q_status_t q_status;
    logic      push;
    item_t     push_item;
    logic      pop;
    item_t     head;

    // classify requests and stamp the current rotor offsets
    rsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    // decouples request acceptance from result stalls
    rsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // rotor tables and lookup pipeline
    rsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .res      (res)
    );

endmodule
